>>> rtl/core/cbl_pkg.sv
// shared types, register codes and reset values of the colour blob locator
package cbl_pkg;

  localparam int PIX_W      = 8;
  localparam int OFF_W      = 17;
  localparam int SIZE_W     = 16;
  localparam int DIMCFG_W   = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int OFFSET_LIMIT = 65535;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DARK_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BREADTH = 3'd5;

  // register reset values
  localparam logic [DIMCFG_W-1:0] RST_FRAME_WIDTH   = 11'd640;
  localparam logic [DIMCFG_W-1:0] RST_FRAME_HEIGHT  = 11'd480;
  localparam logic [PIX_W-1:0]    RST_DARK_LIMIT    = 8'd20;
  localparam logic [PIX_W-1:0]    RST_BRIGHT_LIMIT  = 8'd200;
  localparam logic [SIZE_W-1:0]   RST_TABLE_LENGTH  = 16'd1000;
  localparam logic [SIZE_W-1:0]   RST_TABLE_BREADTH = 16'd1000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MED,
    ST_UPD,
    ST_DILATE,
    ST_MUL,
    ST_DIV,
    ST_LOAD
  } cbl_state_e;

  typedef enum logic {
    AXIS_X,
    AXIS_Y
  } cbl_axis_e;

  typedef struct packed {
    logic      accept;
    logic      sweep_first;
    logic      sweep_next;
    logic      tap_step;
    logic      med_step;
    logic      upd;
    logic      dilate;
    logic      mul;
    logic      div_step;
    logic      store;
    cbl_axis_e axis;
    logic      load;
  } cbl_cmd_t;

  typedef struct packed {
    logic row_end;
    logic frame_end;
    logic row_pos;
    logic tap_last;
    logic med_last;
    logic col_last;
    logic div_last;
    logic out_free;
  } cbl_status_t;

endpackage

>>> rtl/core/cbl_ctrl.sv
// sequencing state machine of the colour blob locator
module cbl_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cbl_pkg::cbl_status_t status_i,
  output cbl_pkg::cbl_cmd_t    cmd_o
);

  cbl_pkg::cbl_state_e state_q, state_d;
  cbl_pkg::cbl_axis_e  axis_q, axis_d;
  logic                final_q, final_d;
  logic                second_q, second_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= cbl_pkg::ST_IDLE;
      axis_q   <= cbl_pkg::AXIS_X;
      final_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      axis_q   <= axis_d;
      final_q  <= final_d;
      second_q <= second_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    axis_d     = axis_q;
    final_d    = final_q;
    second_d   = second_q;
    cmd_o      = '0;
    cmd_o.axis = axis_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      cbl_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          // a finished row lets the row above it be filtered
          if (status_i.row_end && status_i.row_pos) begin
            cmd_o.sweep_first = 1'b1;
            final_d  = status_i.frame_end;
            second_d = 1'b0;
            state_d  = cbl_pkg::ST_READ;
          end
        end
      end
      cbl_pkg::ST_READ: begin
        cmd_o.tap_step = 1'b1;
        if (status_i.tap_last) state_d = cbl_pkg::ST_MED;
      end
      cbl_pkg::ST_MED: begin
        cmd_o.med_step = 1'b1;
        if (status_i.med_last) state_d = cbl_pkg::ST_UPD;
      end
      cbl_pkg::ST_UPD: begin
        cmd_o.upd = 1'b1;
        if (!status_i.col_last) begin
          state_d = cbl_pkg::ST_READ;
        end else if (final_q && !second_q) begin
          // bottom row still to filter, with the border replicated
          cmd_o.sweep_next = 1'b1;
          second_d = 1'b1;
          state_d  = cbl_pkg::ST_READ;
        end else if (final_q) begin
          state_d = cbl_pkg::ST_DILATE;
        end else begin
          state_d = cbl_pkg::ST_IDLE;
        end
      end
      cbl_pkg::ST_DILATE: begin
        cmd_o.dilate = 1'b1;
        axis_d  = cbl_pkg::AXIS_X;
        state_d = cbl_pkg::ST_MUL;
      end
      cbl_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = cbl_pkg::ST_DIV;
      end
      cbl_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          cmd_o.store = 1'b1;
          if (axis_q == cbl_pkg::AXIS_X) begin
            axis_d  = cbl_pkg::AXIS_Y;
            state_d = cbl_pkg::ST_MUL;
          end else begin
            state_d = cbl_pkg::ST_LOAD;
          end
        end
      end
      cbl_pkg::ST_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          final_d    = 1'b0;
          state_d    = cbl_pkg::ST_IDLE;
        end
      end
      default: state_d = cbl_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> rtl/core/cbl_datapath.sv
// line memory, median filter, bounding boxes and offset divider
module cbl_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cbl_pkg::cbl_cmd_t                cmd_i,
  output cbl_pkg::cbl_status_t             status_o,
  input  logic [cbl_pkg::PIX_W-1:0]        red_i,
  input  logic [cbl_pkg::PIX_W-1:0]        green_i,
  input  logic                             frame_start_i,
  input  logic                             cfg_valid_i,
  input  logic [cbl_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [cbl_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic signed [cbl_pkg::OFF_W-1:0] x_offset_o,
  output logic signed [cbl_pkg::OFF_W-1:0] y_offset_o,
  output logic                             object_found_o,
  output logic                             table_found_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int AW = (CW > RW) ? CW + 1 : RW + 1;
  localparam int NB = AW + cbl_pkg::SIZE_W;
  localparam int DCW = $clog2(NB);
  localparam int MEM_DEPTH = 3 * (1 << CW);

  typedef logic [CW-1:0] col_t;
  typedef logic [RW-1:0] row_t;
  typedef logic [CW:0]   wdim_t;
  typedef logic [RW:0]   hdim_t;
  typedef logic [AW-1:0] aw_t;
  typedef logic [NB-1:0] nb_t;

  typedef struct packed {
    logic valid;
    row_t rmin;
    row_t rmax;
    col_t cmin;
    col_t cmax;
  } box_t;

  function automatic wdim_t clamp_w(logic [cbl_pkg::DIMCFG_W-1:0] v);
    logic [12:0] ve;
    ve = {2'b00, v};
    if (ve < 13'd3) return wdim_t'(3);
    if (ve > 13'(MAX_WIDTH)) return wdim_t'(MAX_WIDTH);
    return wdim_t'(ve);
  endfunction

  function automatic hdim_t clamp_h(logic [cbl_pkg::DIMCFG_W-1:0] v);
    logic [12:0] ve;
    ve = {2'b00, v};
    if (ve < 13'd3) return hdim_t'(3);
    if (ve > 13'(MAX_HEIGHT)) return hdim_t'(MAX_HEIGHT);
    return hdim_t'(ve);
  endfunction

  function automatic logic [1:0] prev_slot(logic [1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

  // configuration registers
  logic [cbl_pkg::DIMCFG_W-1:0] fw_q, fh_q;
  logic [cbl_pkg::PIX_W-1:0]    dark_q, bright_q;
  logic [cbl_pkg::SIZE_W-1:0]   length_q, breadth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q      <= cbl_pkg::RST_FRAME_WIDTH;
      fh_q      <= cbl_pkg::RST_FRAME_HEIGHT;
      dark_q    <= cbl_pkg::RST_DARK_LIMIT;
      bright_q  <= cbl_pkg::RST_BRIGHT_LIMIT;
      length_q  <= cbl_pkg::RST_TABLE_LENGTH;
      breadth_q <= cbl_pkg::RST_TABLE_BREADTH;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cbl_pkg::CFG_FRAME_WIDTH:   fw_q      <= cfg_data_i[cbl_pkg::DIMCFG_W-1:0];
        cbl_pkg::CFG_FRAME_HEIGHT:  fh_q      <= cfg_data_i[cbl_pkg::DIMCFG_W-1:0];
        cbl_pkg::CFG_DARK_LIMIT:    dark_q    <= cfg_data_i[cbl_pkg::PIX_W-1:0];
        cbl_pkg::CFG_BRIGHT_LIMIT:  bright_q  <= cfg_data_i[cbl_pkg::PIX_W-1:0];
        cbl_pkg::CFG_TABLE_LENGTH:  length_q  <= cfg_data_i;
        cbl_pkg::CFG_TABLE_BREADTH: breadth_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // raster position and latched frame size
  wdim_t      cur_w_q;
  hdim_t      cur_h_q;
  row_t       row_q;
  col_t       col_q;
  logic [1:0] slot_q;

  wdim_t      eff_w;
  hdim_t      eff_h;
  row_t       eff_row;
  col_t       eff_col;
  logic [1:0] eff_slot;
  logic       col_end, frame_end;

  assign eff_w    = frame_start_i ? clamp_w(fw_q) : cur_w_q;
  assign eff_h    = frame_start_i ? clamp_h(fh_q) : cur_h_q;
  assign eff_row  = frame_start_i ? '0 : row_q;
  assign eff_col  = frame_start_i ? '0 : col_q;
  assign eff_slot = frame_start_i ? 2'd0 : slot_q;
  assign col_end   = ({1'b0, eff_col} == eff_w - wdim_t'(1));
  assign frame_end = col_end && ({1'b0, eff_row} == eff_h - hdim_t'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_w_q <= clamp_w(cbl_pkg::RST_FRAME_WIDTH);
      cur_h_q <= clamp_h(cbl_pkg::RST_FRAME_HEIGHT);
      row_q   <= '0;
      col_q   <= '0;
      slot_q  <= 2'd0;
    end else begin
      if (cmd_i.accept) begin
        cur_w_q <= eff_w;
        cur_h_q <= eff_h;
        if (frame_end) begin
          row_q  <= '0;
          col_q  <= '0;
          slot_q <= 2'd0;
        end else if (col_end) begin
          row_q  <= eff_row + row_t'(1);
          col_q  <= '0;
          slot_q <= (eff_slot == 2'd2) ? 2'd0 : eff_slot + 2'd1;
        end else begin
          row_q  <= eff_row;
          col_q  <= eff_col + col_t'(1);
          slot_q <= eff_slot;
        end
      end
      // new frame size takes effect once the result is out
      if (cmd_i.load) begin
        cur_w_q <= clamp_w(fw_q);
        cur_h_q <= clamp_h(fh_q);
      end
    end
  end

  // three-row line memory, green in the upper byte
  logic [2*cbl_pkg::PIX_W-1:0] mem [0:MEM_DEPTH-1];
  logic [CW+1:0]               wr_addr, rd_addr;

  // sweep control
  row_t       cr_q;
  col_t       cc_q;
  logic [1:0] top_q, mid_q, bot_q;
  logic [3:0] tap_q;
  logic [2:0] bit_q;
  logic [cbl_pkg::PIX_W-1:0] win_r [0:8];
  logic [cbl_pkg::PIX_W-1:0] win_g [0:8];
  logic [cbl_pkg::PIX_W-1:0] med_r_q, med_g_q;

  logic [1:0] rd_slot;
  col_t       rd_col, cc_left, cc_right;
  logic       cc_last;

  assign wr_addr  = {eff_slot, eff_col};
  assign cc_last  = ({1'b0, cc_q} == cur_w_q - wdim_t'(1));
  assign cc_left  = (cc_q == '0) ? cc_q : cc_q - col_t'(1);
  assign cc_right = cc_last ? cc_q : cc_q + col_t'(1);

  always_comb begin
    if (tap_q < 4'd3)      rd_slot = top_q;
    else if (tap_q < 4'd6) rd_slot = mid_q;
    else                   rd_slot = bot_q;
    if (tap_q == 4'd0 || tap_q == 4'd3 || tap_q == 4'd6)      rd_col = cc_left;
    else if (tap_q == 4'd1 || tap_q == 4'd4 || tap_q == 4'd7) rd_col = cc_q;
    else                                                       rd_col = cc_right;
  end

  assign rd_addr = {rd_slot, rd_col};

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) mem[wr_addr] <= {green_i, red_i};
    if (cmd_i.tap_step) begin
      win_r[tap_q] <= mem[rd_addr][cbl_pkg::PIX_W-1:0];
      win_g[tap_q] <= mem[rd_addr][2*cbl_pkg::PIX_W-1:cbl_pkg::PIX_W];
    end
  end

  // median by bit search: largest value with at most four window entries below it
  logic [cbl_pkg::PIX_W-1:0] cand_r, cand_g;
  logic [8:0]                lt_r, lt_g;

  assign cand_r = med_r_q | (8'd1 << bit_q);
  assign cand_g = med_g_q | (8'd1 << bit_q);

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      lt_r[i] = (win_r[i] < cand_r);
      lt_g[i] = (win_g[i] < cand_g);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
      bit_q <= 3'd7;
    end else begin
      if (cmd_i.sweep_first || cmd_i.sweep_next || cmd_i.upd) begin
        tap_q <= '0;
        bit_q <= 3'd7;
      end else if (cmd_i.tap_step) begin
        tap_q <= tap_q + 4'd1;
      end else if (cmd_i.med_step) begin
        bit_q <= bit_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_first) begin
      cr_q  <= eff_row - row_t'(1);
      cc_q  <= '0;
      bot_q <= eff_slot;
      mid_q <= prev_slot(eff_slot);
      top_q <= (eff_row == row_t'(1)) ? prev_slot(eff_slot) : prev_slot(prev_slot(eff_slot));
    end else if (cmd_i.sweep_next) begin
      cr_q  <= cr_q + row_t'(1);
      cc_q  <= '0;
      top_q <= mid_q;
      mid_q <= bot_q;
    end else if (cmd_i.upd) begin
      cc_q <= cc_q + col_t'(1);
    end
    if (cmd_i.tap_step && tap_q == 4'd8) begin
      med_r_q <= '0;
      med_g_q <= '0;
    end else if (cmd_i.med_step) begin
      if ($countones(lt_r) <= 4) med_r_q <= cand_r;
      if ($countones(lt_g) <= 4) med_g_q <= cand_g;
    end
  end

  // bounding boxes
  box_t tbox_q, obox_q;
  logic table_hit, object_hit;

  assign table_hit  = (med_r_q < dark_q) && (win_g[4] < dark_q);
  assign object_hit = (med_g_q > bright_q);

  function automatic box_t box_add(box_t b, row_t r, col_t c);
    box_t n;
    n = b;
    if (!b.valid) begin
      n.valid = 1'b1;
      n.rmin = r;
      n.rmax = r;
      n.cmin = c;
      n.cmax = c;
    end else begin
      if (r < b.rmin) n.rmin = r;
      if (r > b.rmax) n.rmax = r;
      if (c < b.cmin) n.cmin = c;
      if (c > b.cmax) n.cmax = c;
    end
    return n;
  endfunction

  function automatic box_t box_grow(box_t b, wdim_t w, hdim_t h);
    box_t n;
    n = b;
    if (b.rmin != '0) n.rmin = b.rmin - row_t'(1);
    if (b.cmin != '0) n.cmin = b.cmin - col_t'(1);
    if ({1'b0, b.rmax} + hdim_t'(1) < h) n.rmax = b.rmax + row_t'(1);
    if ({1'b0, b.cmax} + wdim_t'(1) < w) n.cmax = b.cmax + col_t'(1);
    return n;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbox_q <= '0;
      obox_q <= '0;
    end else begin
      if ((cmd_i.accept && frame_start_i) || cmd_i.load) begin
        tbox_q.valid <= 1'b0;
        obox_q.valid <= 1'b0;
      end else if (cmd_i.upd) begin
        if (table_hit)  tbox_q <= box_add(tbox_q, cr_q, cc_q);
        if (object_hit) obox_q <= box_add(obox_q, cr_q, cc_q);
      end else if (cmd_i.dilate) begin
        if (tbox_q.valid) tbox_q <= box_grow(tbox_q, cur_w_q, cur_h_q);
        if (obox_q.valid) obox_q <= box_grow(obox_q, cur_w_q, cur_h_q);
      end
    end
  end

  // offset: (centre - frame centre) * size / table extent, shift-subtract division
  aw_t  pos, cen, den, ext, mag;
  logic [AW:0] diff;
  logic [cbl_pkg::SIZE_W-1:0] size;

  always_comb begin
    if (cmd_i.axis == cbl_pkg::AXIS_X) begin
      ext  = aw_t'(obox_q.cmax - obox_q.cmin) + aw_t'(1);
      pos  = aw_t'(obox_q.cmin) + (ext >> 1);
      cen  = aw_t'(cur_w_q >> 1);
      den  = aw_t'(tbox_q.cmax - tbox_q.cmin) + aw_t'(1);
      size = breadth_q;
    end else begin
      ext  = aw_t'(obox_q.rmax - obox_q.rmin) + aw_t'(1);
      pos  = aw_t'(obox_q.rmin) + (ext >> 1);
      cen  = aw_t'(cur_h_q >> 1);
      den  = aw_t'(tbox_q.rmax - tbox_q.rmin) + aw_t'(1);
      size = length_q;
    end
    diff = {1'b0, pos} - {1'b0, cen};
    mag  = diff[AW] ? aw_t'(-diff) : diff[AW-1:0];
  end

  nb_t        num_q, quo_q, quo_next;
  aw_t        den_q, rem_q, rem_next;
  logic       neg_q;
  logic [DCW-1:0] dcnt_q;
  logic [AW:0] rem_sh;

  always_comb begin
    rem_sh = {rem_q, num_q[NB-1]};
    if (rem_sh >= {1'b0, den_q}) begin
      rem_next = aw_t'(rem_sh - {1'b0, den_q});
      quo_next = {quo_q[NB-2:0], 1'b1};
    end else begin
      rem_next = rem_sh[AW-1:0];
      quo_next = {quo_q[NB-2:0], 1'b0};
    end
  end

  logic [cbl_pkg::SIZE_W-1:0] sat;
  logic [cbl_pkg::OFF_W-1:0]  sat_ext, signed_val;

  assign sat        = (quo_next > nb_t'(cbl_pkg::OFFSET_LIMIT)) ? 16'hFFFF
                                                               : quo_next[cbl_pkg::SIZE_W-1:0];
  assign sat_ext    = {1'b0, sat};
  assign signed_val = neg_q ? -sat_ext : sat_ext;

  logic signed [cbl_pkg::OFF_W-1:0] xr_q, yr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.mul) begin
      dcnt_q <= DCW'(NB - 1);
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q - DCW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      num_q <= nb_t'(mag) * nb_t'(size);
      den_q <= den;
      neg_q <= diff[AW];
      rem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[NB-2:0], 1'b0};
      rem_q <= rem_next;
      quo_q <= quo_next;
    end
    if (cmd_i.store) begin
      if (cmd_i.axis == cbl_pkg::AXIS_X) xr_q <= signed_val;
      else                               yr_q <= signed_val;
    end
  end

  // result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      object_found_o <= obox_q.valid;
      table_found_o  <= tbox_q.valid;
      x_offset_o     <= (obox_q.valid && tbox_q.valid) ? xr_q : '0;
      y_offset_o     <= (obox_q.valid && tbox_q.valid) ? yr_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;

  assign status_o.row_end   = col_end;
  assign status_o.frame_end = frame_end;
  assign status_o.row_pos   = (eff_row != '0);
  assign status_o.tap_last  = (tap_q == 4'd8);
  assign status_o.med_last  = (bit_q == 3'd0);
  assign status_o.col_last  = cc_last;
  assign status_o.div_last  = (dcnt_q == '0);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

>>> rtl/core/color_blob_locator_unit.sv
// top level of the colour blob locator
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata red, green; tuser frame start
//  m_axis    out  m_axis_tvalid/tready       tdata x, y offsets; tuser found flags
//  cfg       in   cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
// pixels are accepted only while the controller is idle; the last pixel of each row from the second row on
// starts a filter pass over the row above, with nine line memory reads, eight median bit steps
// and one box update per column.
// the last pixel of a frame adds the pass over the bottom row, a box dilation and two multiplies
// with shift-subtract divisions before the result is loaded.
// reset clears control state, configuration registers and bounding boxes; the line memory needs no clearing.
// a stalled result holds the output register, the next frame waits only at its end.
module color_blob_locator_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,  // pixel_red, pixel_green
  input  logic [0:0]                     s_axis_tuser,  // frame_start
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [39:0]                    m_axis_tdata,  // object_x_offset, object_y_offset, pad
  output logic [1:0]                     m_axis_tuser,  // object_found, table_found
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cbl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cbl_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  cbl_pkg::cbl_cmd_t    cmd;
  cbl_pkg::cbl_status_t status;

  logic signed [cbl_pkg::OFF_W-1:0] x_off, y_off;
  logic                             obj_found, tab_found;

  cbl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cbl_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .red_i          (s_axis_tdata[7:0]),
    .green_i        (s_axis_tdata[15:8]),
    .frame_start_i  (s_axis_tuser[0]),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .x_offset_o     (x_off),
    .y_offset_o     (y_off),
    .object_found_o (obj_found),
    .table_found_o  (tab_found)
  );

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {6'b0, y_off, x_off};
  assign m_axis_tuser = {tab_found, obj_found};

endmodule
